@@ sv/mexp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

	// operand and exponent widths
	localparam int OPERAND_WIDTH  = 32;
	localparam int EXPONENT_WIDTH = 32;

	// stream packing, padded to whole bytes
	localparam int IN_BITS       = 2 * OPERAND_WIDTH + EXPONENT_WIDTH;
	localparam int IN_DATA_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W    = ((OPERAND_WIDTH + 7) / 8) * 8;

	// counter widths
	localparam int MUL_CNT_W = $clog2(OPERAND_WIDTH);
	localparam int EXP_CNT_W = (EXPONENT_WIDTH > 1) ? $clog2(EXPONENT_WIDTH) : 1;

	typedef logic [OPERAND_WIDTH-1:0]  operand_t;
	typedef logic [EXPONENT_WIDTH-1:0] exponent_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_SQUARE,
		S_MULT,
		S_DONE
	} seq_state_t;

	// request to the modular multiplier, taken when start is high
	typedef struct packed {
		logic     start;
		operand_t a;
		operand_t b;
		operand_t m;
	} mm_req_t;

	// product of the modular multiplier, valid while done is high
	typedef struct packed {
		logic     done;
		operand_t prod;
	} mm_rsp_t;

	// finished result from the sequencer
	typedef struct packed {
		logic     valid;
		logic     err;
		operand_t residue;
	} seq_res_t;

endpackage

`default_nettype wire

@@ sv/mexp_mulmod.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mexp_pkg::mm_req_t req,
	output mexp_pkg::mm_rsp_t     rsp
);

	logic [mexp_pkg::OPERAND_WIDTH-1:0] a_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] b_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] m_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] acc_q;
	logic [mexp_pkg::MUL_CNT_W-1:0]     cnt_q;
	logic                               busy_q;
	logic                               done_q;

	logic [mexp_pkg::OPERAND_WIDTH+1:0] sum;
	logic [mexp_pkg::OPERAND_WIDTH+1:0] m1;
	logic [mexp_pkg::OPERAND_WIDTH+1:0] m2;
	logic [mexp_pkg::OPERAND_WIDTH+1:0] red;

	// one multiplier bit per cycle: acc = 2*acc + bit*a, then bring below m
	always_comb begin
		m1  = {2'b00, m_q};
		m2  = {1'b0, m_q, 1'b0};
		sum = {1'b0, acc_q, 1'b0}
			+ (b_q[mexp_pkg::OPERAND_WIDTH-1] ? {2'b00, a_q} : '0);
		if (sum >= m2) begin
			red = sum - m2;
		end else if (sum >= m1) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
	end

	// control: busy while the multiplier bits are worked through, then a done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= mexp_pkg::MUL_CNT_W'(mexp_pkg::OPERAND_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand shift register and accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			m_q   <= req.m;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q << 1;
			acc_q <= red[mexp_pkg::OPERAND_WIDTH-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

`default_nettype wire

@@ sv/mexp_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mexp_seq (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [mexp_pkg::OPERAND_WIDTH-1:0]  in_base,
	input  wire logic [mexp_pkg::EXPONENT_WIDTH-1:0] in_exponent,
	input  wire logic [mexp_pkg::OPERAND_WIDTH-1:0]  in_modulus,
	output mexp_pkg::mm_req_t                        mm_req,
	input  wire mexp_pkg::mm_rsp_t                   mm_rsp,
	output mexp_pkg::seq_res_t                       res,
	input  wire logic                                res_ready
);

	mexp_pkg::seq_state_t state_q, state_d;

	mexp_pkg::operand_t             base_q, base_d;
	mexp_pkg::operand_t             mod_q, mod_d;
	mexp_pkg::operand_t             r_q, r_d;
	mexp_pkg::exponent_t            exp_q, exp_d;
	logic [mexp_pkg::EXP_CNT_W-1:0] cnt_q, cnt_d;
	logic                           err_q, err_d;
	mexp_pkg::operand_t             one_in;
	mexp_pkg::operand_t             one_q;

	// 1 mod m for the incoming and the held modulus
	assign one_in = (in_modulus == mexp_pkg::OPERAND_WIDTH'(1)) ? '0 :
		mexp_pkg::OPERAND_WIDTH'(1);
	assign one_q  = (mod_q == mexp_pkg::OPERAND_WIDTH'(1)) ? '0 :
		mexp_pkg::OPERAND_WIDTH'(1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		base_q <= base_d;
		mod_q  <= mod_d;
		r_q    <= r_d;
		exp_q  <= exp_d;
		cnt_q  <= cnt_d;
		err_q  <= err_d;
	end

	// next state: reduce the base, then square per exponent bit and multiply per set bit
	always_comb begin
		state_d      = state_q;
		base_d       = base_q;
		mod_d        = mod_q;
		r_d          = r_q;
		exp_d        = exp_q;
		cnt_d        = cnt_q;
		err_d        = err_q;
		in_ready     = 1'b0;
		mm_req.start = 1'b0;
		mm_req.a     = '0;
		mm_req.b     = '0;
		mm_req.m     = mod_q;
		res.valid    = 1'b0;
		res.err      = err_q;
		res.residue  = r_q;

		case (state_q)
			mexp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mod_d = in_modulus;
					exp_d = in_exponent;
					cnt_d = mexp_pkg::EXP_CNT_W'(mexp_pkg::EXPONENT_WIDTH - 1);
					if (in_modulus == '0) begin
						err_d   = 1'b1;
						r_d     = '0;
						state_d = mexp_pkg::S_DONE;
					end else begin
						// base mod m as the product (1 mod m) * base
						err_d        = 1'b0;
						mm_req.start = 1'b1;
						mm_req.a     = one_in;
						mm_req.b     = in_base;
						mm_req.m     = in_modulus;
						state_d      = mexp_pkg::S_REDUCE;
					end
				end
			end
			mexp_pkg::S_REDUCE: begin
				if (mm_rsp.done) begin
					base_d       = mm_rsp.prod;
					r_d          = one_q;
					mm_req.start = 1'b1;
					mm_req.a     = one_q;
					mm_req.b     = one_q;
					state_d      = mexp_pkg::S_SQUARE;
				end
			end
			mexp_pkg::S_SQUARE: begin
				if (mm_rsp.done) begin
					r_d = mm_rsp.prod;
					if (exp_q[mexp_pkg::EXPONENT_WIDTH-1]) begin
						mm_req.start = 1'b1;
						mm_req.a     = mm_rsp.prod;
						mm_req.b     = base_q;
						state_d      = mexp_pkg::S_MULT;
					end else if (cnt_q == '0) begin
						state_d = mexp_pkg::S_DONE;
					end else begin
						exp_d        = exp_q << 1;
						cnt_d        = cnt_q - 1'b1;
						mm_req.start = 1'b1;
						mm_req.a     = mm_rsp.prod;
						mm_req.b     = mm_rsp.prod;
					end
				end
			end
			mexp_pkg::S_MULT: begin
				if (mm_rsp.done) begin
					r_d = mm_rsp.prod;
					if (cnt_q == '0) begin
						state_d = mexp_pkg::S_DONE;
					end else begin
						exp_d        = exp_q << 1;
						cnt_d        = cnt_q - 1'b1;
						mm_req.start = 1'b1;
						mm_req.a     = mm_rsp.prod;
						mm_req.b     = mm_rsp.prod;
						state_d      = mexp_pkg::S_SQUARE;
					end
				end
			end
			mexp_pkg::S_DONE: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = mexp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mexp_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/modular_exponentiation_top.sv @@
// a zero modulus goes straight to the result with the error flag; otherwise the one bit-serial
//   modular multiplier runs once to reduce the base, once per exponent bit to square and
//   once per set exponent bit to multiply
// throughput: one item at a time; the next beat is taken once the result sits in the
//   output register, while that result waits for the sink
// reset: arst_n clears the sequencer state, the multiplier control and the output valid, payload registers keep junk
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// base, exponent, modulus
	input  wire logic [mexp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// residue
	output logic [mexp_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// zero_modulus_error
	output logic                                  m_axis_tuser
);

	localparam int W = mexp_pkg::OPERAND_WIDTH;
	localparam int E = mexp_pkg::EXPONENT_WIDTH;

	mexp_pkg::mm_req_t  mm_req;
	mexp_pkg::mm_rsp_t  mm_rsp;
	mexp_pkg::seq_res_t res;
	logic               res_ready;

	logic               out_valid_q;
	mexp_pkg::operand_t out_residue_q;
	logic               out_err_q;

	// unpack the input beat
	mexp_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_base     (s_axis_tdata[W-1:0]),
		.in_exponent (s_axis_tdata[W+E-1:W]),
		.in_modulus  (s_axis_tdata[2*W+E-1:W+E]),
		.mm_req      (mm_req),
		.mm_rsp      (mm_rsp),
		.res         (res),
		.res_ready   (res_ready)
	);

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_residue_q <= res.residue;
			out_err_q     <= res.err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = mexp_pkg::OUT_DATA_W'(out_residue_q);
	assign m_axis_tuser  = out_err_q;

	// an error beat carries a zero residue
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("error beat with nonzero residue");

	// an accepted beat makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after accept");

	// the multiplier only finishes while an item is in work
	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> !s_axis_tready)
		else $error("multiplier done while idle");

	// a result reaches the sequencer output only when no multiply is started
	a_no_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !mm_req.start)
		else $error("multiply started while result pending");

endmodule

`default_nettype wire
